FILE: sv/rasi_pkg.sv
// ----------------------------------------------------------------------------
// rasi_pkg
// Shared types and constants for the ray versus box slab test pipeline.
// ----------------------------------------------------------------------------
package rasi_pkg;

   // Default coordinate width (signed fixed point, Q16.16 by default)
   localparam int COORD_WIDTH_DEF = 32;

   // Number of coordinate fields in one request
   localparam int NUM_FIELDS = 12;

   // Distances are signed 64-bit, saturated at the limits
   localparam int DIST_W = 64;

   typedef logic signed [DIST_W-1:0] dist_type;

   localparam dist_type DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
   localparam dist_type DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

   // Field positions inside the request tdata, in units of one coordinate
   localparam int F_MIN_X = 0;
   localparam int F_MAX_X = 3;
   localparam int F_ORG_X = 6;
   localparam int F_INV_X = 9;

   // Stage enables of the per-axis distance pipeline
   typedef struct packed {
      logic diff;   // plane select and subtract
      logic mul;    // full product
      logic sat;    // clamp to distance range
   } slab_en_type;

   // Stage enables of the interval merge pipeline
   typedef struct packed {
      logic xy;     // merge x and y intervals
      logic z;      // merge z interval
      logic fin;    // final hit decision
   } merge_en_type;

endpackage

FILE: sv/rasi_slab.sv
// ----------------------------------------------------------------------------
// rasi_slab
// Entry and exit distance of one axis: plane select, subtract, multiply by
// the inverse direction, then saturate to the signed 64-bit range.
// ----------------------------------------------------------------------------
module rasi_slab #(
   parameter int COORD_WIDTH = rasi_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic signed [COORD_WIDTH-1:0]  lo,
   input  logic signed [COORD_WIDTH-1:0]  hi,
   input  logic signed [COORD_WIDTH-1:0]  org,
   input  logic signed [COORD_WIDTH-1:0]  inv,
   input  rasi_pkg::slab_en_type          en,
   output rasi_pkg::dist_type             near_dist,
   output rasi_pkg::dist_type             far_dist
);
   import rasi_pkg::*;

   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = DIFF_W + COORD_WIDTH;
   localparam int EXT_W  = (PROD_W > DIST_W + 1) ? PROD_W : DIST_W + 1;

   logic signed [DIFF_W-1:0]      near_diff_ff, near_diff_in;
   logic signed [DIFF_W-1:0]      far_diff_ff, far_diff_in;
   logic signed [COORD_WIDTH-1:0] inv_ff;
   logic signed [PROD_W-1:0]      near_prod_ff, near_prod_in;
   logic signed [PROD_W-1:0]      far_prod_ff, far_prod_in;
   dist_type                      near_ff, near_in;
   dist_type                      far_ff, far_in;

   // Negative inverse direction puts the max plane first
   always_comb begin
      if (inv[COORD_WIDTH-1]) begin
         near_diff_in = DIFF_W'(hi) - DIFF_W'(org);
         far_diff_in  = DIFF_W'(lo) - DIFF_W'(org);
      end else begin
         near_diff_in = DIFF_W'(lo) - DIFF_W'(org);
         far_diff_in  = DIFF_W'(hi) - DIFF_W'(org);
      end
   end

   // Exact products
   assign near_prod_in = PROD_W'(near_diff_ff) * PROD_W'(inv_ff);
   assign far_prod_in  = PROD_W'(far_diff_ff) * PROD_W'(inv_ff);

   // Clamp to the distance range
   function automatic dist_type sat_dist(input logic signed [PROD_W-1:0] p);
      logic signed [EXT_W-1:0]      ext;
      logic [EXT_W-DIST_W:0]        upper;
      ext   = EXT_W'(p);
      upper = ext[EXT_W-1:DIST_W-1];
      if ((&upper) || !(|upper)) begin
         sat_dist = ext[DIST_W-1:0];
      end else if (ext[EXT_W-1]) begin
         sat_dist = DIST_MIN;
      end else begin
         sat_dist = DIST_MAX;
      end
   endfunction

   assign near_in = sat_dist(near_prod_ff);
   assign far_in  = sat_dist(far_prod_ff);

   // Pipeline registers, payload only
   always_ff @(posedge clock) begin
      if (en.diff) begin
         near_diff_ff <= near_diff_in;
         far_diff_ff  <= far_diff_in;
         inv_ff       <= inv;
      end
      if (en.mul) begin
         near_prod_ff <= near_prod_in;
         far_prod_ff  <= far_prod_in;
      end
      if (en.sat) begin
         near_ff <= near_in;
         far_ff  <= far_in;
      end
   end

   assign near_dist = near_ff;
   assign far_dist  = far_ff;

endmodule

FILE: sv/rasi_merge.sv
// ----------------------------------------------------------------------------
// rasi_merge
// Narrows the x, y and z intervals one axis per stage and decides the hit.
// ----------------------------------------------------------------------------
module rasi_merge (
   input  logic                   clock,
   input  rasi_pkg::dist_type     near_x,
   input  rasi_pkg::dist_type     far_x,
   input  rasi_pkg::dist_type     near_y,
   input  rasi_pkg::dist_type     far_y,
   input  rasi_pkg::dist_type     near_z,
   input  rasi_pkg::dist_type     far_z,
   input  rasi_pkg::merge_en_type en,
   output logic                   hit
);
   import rasi_pkg::*;

   logic     miss1_ff, miss1_in;
   dist_type tmin1_ff, tmin1_in;
   dist_type tmax1_ff, tmax1_in;
   dist_type nz_ff, fz_ff;
   logic     miss2_ff, miss2_in;
   dist_type tmin2_ff, tmin2_in;
   dist_type tmax2_ff, tmax2_in;
   logic     hit_ff, hit_in;

   // x against y
   always_comb begin
      miss1_in = (near_x > far_y) || (near_y > far_x);
      tmin1_in = (near_y > near_x) ? near_y : near_x;
      tmax1_in = (far_y < far_x) ? far_y : far_x;
   end

   // merged interval against z; an earlier miss sticks
   always_comb begin
      miss2_in = miss1_ff || (tmin1_ff > fz_ff) || (nz_ff > tmax1_ff);
      tmin2_in = (nz_ff > tmin1_ff) ? nz_ff : tmin1_ff;
      tmax2_in = (fz_ff < tmax1_ff) ? fz_ff : tmax1_ff;
   end

   // Entry below the saturated maximum, exit beyond zero
   assign hit_in = !miss2_ff && (tmin2_ff < DIST_MAX) && (tmax2_ff > dist_type'(0));

   always_ff @(posedge clock) begin
      if (en.xy) begin
         miss1_ff <= miss1_in;
         tmin1_ff <= tmin1_in;
         tmax1_ff <= tmax1_in;
         nz_ff    <= near_z;
         fz_ff    <= far_z;
      end
      if (en.z) begin
         miss2_ff <= miss2_in;
         tmin2_ff <= tmin2_in;
         tmax2_ff <= tmax2_in;
      end
      if (en.fin) begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

FILE: sv/ray_aabb_slab_intersection_top.sv
// ----------------------------------------------------------------------------
// ray_aabb_slab_intersection_top
// Streaming ray versus axis-aligned box slab test.
// ----------------------------------------------------------------------------
// One box/ray pair per request transfer gives one hit flag per response
// transfer, in order. The block accepts one request every clock cycle unless
// all stages are full and the response side stalls, and passes each through
// six register stages (subtract, multiply, saturate, x/y merge, z merge,
// decision). Each stage only holds while the stage after it is full and
// stalled, so bubbles close up and a waiting result does not block intake
// until all six stages are occupied. Coordinates are signed fixed point of
// COORD_WIDTH bits; the binary point does not affect the test.
// ----------------------------------------------------------------------------
module ray_aabb_slab_intersection_top #(
   parameter int COORD_WIDTH = rasi_pkg::COORD_WIDTH_DEF,
   parameter int REQ_DATA_W  = ((rasi_pkg::NUM_FIELDS * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // low to high: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
   // box_max_z, ray_origin_x, ray_origin_y, ray_origin_z, inv_dir_x,
   // inv_dir_y, inv_dir_z, then zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // low to high: hit, then zero fill
   output logic [7:0]            rsp_tdata
);
   import rasi_pkg::*;

   localparam int NUM_STAGES = 6;

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] en;
   slab_en_type           slab_en;
   merge_en_type          merge_en;
   dist_type              near_d [3];
   dist_type              far_d  [3];
   logic                  hit;

   // Stage enables: a stage loads when empty or when its successor loads
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   assign slab_en  = '{diff: en[0], mul: en[1], sat: en[2]};
   assign merge_en = '{xy: en[3], z: en[4], fin: en[5]};

   // Valid bits travel with the data
   always_comb begin
      valid_in = valid_ff;
      if (en[0]) begin
         valid_in[0] = req_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (en[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // One distance pipeline per axis
   for (genvar a = 0; a < 3; a++) begin : g_axis
      rasi_slab #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_slab (
         .clock     (clock),
         .lo        (req_tdata[(F_MIN_X + a) * COORD_WIDTH +: COORD_WIDTH]),
         .hi        (req_tdata[(F_MAX_X + a) * COORD_WIDTH +: COORD_WIDTH]),
         .org       (req_tdata[(F_ORG_X + a) * COORD_WIDTH +: COORD_WIDTH]),
         .inv       (req_tdata[(F_INV_X + a) * COORD_WIDTH +: COORD_WIDTH]),
         .en        (slab_en),
         .near_dist (near_d[a]),
         .far_dist  (far_d[a])
      );
   end

   rasi_merge u_merge (
      .clock  (clock),
      .near_x (near_d[0]),
      .far_x  (far_d[0]),
      .near_y (near_d[1]),
      .far_y  (far_d[1]),
      .near_z (near_d[2]),
      .far_z  (far_d[2]),
      .en     (merge_en),
      .hit    (hit)
   );

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = {7'b0, hit};

   // A full, stalled pipeline takes nothing in
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_tready |-> !req_tready)
      else $error("request taken while pipeline full and stalled");

   // An accepted request lands in the first stage
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted request lost at stage 0");

   // A held item in the middle of the pipeline is not dropped
   a_hold_mid: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] && !en[3] |=> valid_ff[3])
      else $error("stalled item dropped at merge stage");

   // The saturate stage, when it advances with data, hands it to the x/y merge stage
   a_advance: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && en[3] |=> valid_ff[3])
      else $error("item lost between slab and merge stages");

endmodule

FILE: tb/ray_aabb_slab_intersection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_aabb_slab_intersection_checker
// Watches the request and response streams of the slab test block. Each
// request transfer is run through a bit-exact slab predictor and the
// expected hit flag is queued. Each response transfer is compared with the
// oldest queued flag. The mismatch count and the number of outstanding
// flags go to the testbench top.
// ----------------------------------------------------------------------------
module ray_aabb_slab_intersection_checker #(
   parameter int CW    = rasi_pkg::COORD_WIDTH_DEF,
   parameter int REQ_W = ((rasi_pkg::NUM_FIELDS * CW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [7:0]       rsp_tdata,
   output int               mismatch_count,
   output int               hits_pending
);
   import rasi_pkg::*;

   typedef logic signed [CW-1:0] coord_type;

   logic expected_hits[$];
   int   errors = 0;

   // (plane - origin) * inv_dir, exact, then clamped to the distance range
   function automatic dist_type plane_distance(input coord_type plane,
                                               input coord_type origin,
                                               input coord_type inv_dir);
      logic signed [CW:0]       offset;
      logic signed [2*CW+1:0]   product;
      offset  = plane - origin;
      product = offset * inv_dir;
      if (product > DIST_MAX)
         return DIST_MAX;
      if (product < DIST_MIN)
         return DIST_MIN;
      return dist_type'(product);
   endfunction

   // Slab test over x, y, z with early exit on a disjoint interval
   function automatic logic predict_hit(input logic [REQ_W-1:0] pair);
      coord_type lo_plane, hi_plane, origin, inv_dir;
      dist_type  t_enter, t_exit, near_d, far_d;
      int        axis;
      t_enter = '0;
      t_exit  = '0;
      for (axis = 0; axis < 3; axis++) begin
         lo_plane = pair[(F_MIN_X + axis) * CW +: CW];
         hi_plane = pair[(F_MAX_X + axis) * CW +: CW];
         origin   = pair[(F_ORG_X + axis) * CW +: CW];
         inv_dir  = pair[(F_INV_X + axis) * CW +: CW];
         // negative direction enters through the max plane
         if (inv_dir < 0) begin
            near_d = plane_distance(hi_plane, origin, inv_dir);
            far_d  = plane_distance(lo_plane, origin, inv_dir);
         end else begin
            near_d = plane_distance(lo_plane, origin, inv_dir);
            far_d  = plane_distance(hi_plane, origin, inv_dir);
         end
         if (axis == 0) begin
            t_enter = near_d;
            t_exit  = far_d;
         end else begin
            if (t_enter > far_d || near_d > t_exit)
               return 1'b0;
            if (near_d > t_enter)
               t_enter = near_d;
            if (far_d < t_exit)
               t_exit = far_d;
         end
      end
      return (t_enter < DIST_MAX) && (t_exit > 0);
   endfunction

   // Sampled at the clock edge: both sides are driven by nonblocking updates
   always @(posedge clock) begin : scoreboard
      logic want;
      if (reset) begin
         expected_hits.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %02h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_hits.pop_front();
               if (rsp_tdata[0] !== want) begin
                  $display("%0t: hit mismatch, expected %0b actual %0b",
                           $time, want, rsp_tdata[0]);
                  errors++;
               end
               if (rsp_tdata[7:1] !== 7'd0) begin
                  $display("%0t: fill mismatch, expected 00 actual %02h",
                           $time, rsp_tdata[7:1]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_hits.push_back(predict_hit(req_tdata));
      end
      mismatch_count <= errors;
      hits_pending   <= expected_hits.size();
   end

endmodule

FILE: tb/ray_aabb_slab_intersection_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_aabb_slab_intersection_top_tb
// Stream test of the ray versus box slab test block. A directed set covers
// field extremes, each ray direction sign, zero directions, swapped corners
// and intervals that touch zero; random box/ray pairs follow, some of them
// with the ray origin inside the box. Both stream sides pause at random.
// The checker instance predicts and compares every hit flag.
// ----------------------------------------------------------------------------
module ray_aabb_slab_intersection_top_tb;

   localparam int CW           = rasi_pkg::COORD_WIDTH_DEF;
   localparam int REQ_W        = ((rasi_pkg::NUM_FIELDS * CW + 7) / 8) * 8;
   localparam int RANDOM_PAIRS = 1650;
   localparam int DRAIN_CYCLES = 30;

   typedef logic signed [CW-1:0] coord_type;

   localparam coord_type ONE  = 32'sh0001_0000;
   localparam coord_type MAXC = 32'sh7fff_ffff;
   localparam coord_type MINC = 32'sh8000_0000;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;
   int               mismatch_count;
   int               hits_pending;
   logic             calm_phase = 1'b0;

   ray_aabb_slab_intersection_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ray_aabb_slab_intersection_checker #(
      .CW    (CW),
      .REQ_W (REQ_W)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .hits_pending   (hits_pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Pause length: mostly none or short, now and then long
   function automatic int idle_cycles();
      int r;
      if (calm_phase)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Random coordinate with a random magnitude
   function automatic coord_type scaled_coord();
      return coord_type'($urandom) >>> $urandom_range(0, 31);
   endfunction

   function automatic logic [REQ_W-1:0] make_pair(
      input coord_type min_x, input coord_type min_y, input coord_type min_z,
      input coord_type max_x, input coord_type max_y, input coord_type max_z,
      input coord_type org_x, input coord_type org_y, input coord_type org_z,
      input coord_type inv_x, input coord_type inv_y, input coord_type inv_z);
      return {inv_z, inv_y, inv_x, org_z, org_y, org_x,
              max_z, max_y, max_x, min_z, min_y, min_x};
   endfunction

   // Mostly boxes with a ray placed inside or anywhere; some raw noise
   function automatic logic [REQ_W-1:0] random_pair();
      coord_type        lo[3], hi[3], org[3], inv[3];
      coord_type        span, swap;
      logic [REQ_W-1:0] pair;
      int               style, a, r;
      style = $urandom_range(0, 99);
      if (style < 20) begin
         for (a = 0; a < REQ_W / 32; a++)
            pair[a*32 +: 32] = $urandom;
         return pair;
      end
      for (a = 0; a < 3; a++) begin
         lo[a] = scaled_coord();
         span  = coord_type'($urandom_range(0, 32'h7fff_ffff)) >>> $urandom_range(0, 30);
         hi[a] = lo[a] + span;
         if (style < 55)
            org[a] = lo[a] + (span >>> $urandom_range(1, 4));
         else
            org[a] = scaled_coord();
         r = $urandom_range(0, 19);
         if (r == 0)
            inv[a] = '0;
         else if (r == 1)
            inv[a] = $urandom_range(0, 1) ? MAXC : MINC;
         else
            inv[a] = scaled_coord();
         if ($urandom_range(0, 99) < 8) begin
            swap  = lo[a];
            lo[a] = hi[a];
            hi[a] = swap;
         end
      end
      return make_pair(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                       org[0], org[1], org[2], inv[0], inv[1], inv[2]);
   endfunction

   // One request transfer, with an optional pause in front of it
   task automatic send_pair(input logic [REQ_W-1:0] pair);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pair;
      do @(posedge clock); while (!req_tready);
   endtask

   // Response side: stalls of random length between short ready runs
   initial begin : sink_pacing
      int n;
      @(posedge clock);
      forever begin
         n = idle_cycles();
         repeat (n) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end
         n = $urandom_range(1, 8);
         repeat (n) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // all zero: zero directions give an interval ending at zero
      send_pair(make_pair('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
      // origin inside a unit box, positive and negative directions
      send_pair(make_pair(-ONE, -ONE, -ONE, ONE, ONE, ONE, '0, '0, '0, ONE, ONE, ONE));
      send_pair(make_pair(-ONE, -ONE, -ONE, ONE, ONE, ONE, '0, '0, '0, -ONE, -ONE, -ONE));
      // box ahead on x, behind on x, behind but ray reversed
      send_pair(make_pair(2*ONE, -ONE, -ONE, 3*ONE, ONE, ONE, '0, '0, '0, ONE, MAXC, MAXC));
      send_pair(make_pair(-3*ONE, -ONE, -ONE, -2*ONE, ONE, ONE, '0, '0, '0,
                          ONE, MAXC, MAXC));
      send_pair(make_pair(-3*ONE, -ONE, -ONE, -2*ONE, ONE, ONE, '0, '0, '0,
                          -ONE, MAXC, MAXC));
      // zero direction on one axis
      send_pair(make_pair(-ONE, -ONE, -ONE, ONE, ONE, ONE, '0, '0, '0, '0, ONE, ONE));
      send_pair(make_pair(-ONE, -ONE, -ONE, ONE, ONE, ONE, '0, ONE/2, '0, ONE, '0, -ONE));
      // disjoint after x/y, disjoint at z, hit after all three axes
      send_pair(make_pair(2*ONE, 5*ONE, -ONE, 3*ONE, 6*ONE, ONE, '0, '0, '0, ONE, ONE, ONE));
      send_pair(make_pair(2*ONE, 2*ONE, 5*ONE, 3*ONE, 3*ONE, 6*ONE, '0, '0, '0,
                          ONE, ONE, ONE));
      send_pair(make_pair(2*ONE, 3*ONE, 7*ONE/2, 4*ONE, 5*ONE, 6*ONE, '0, '0, '0,
                          ONE, ONE, ONE));
      // interval ending exactly at zero
      send_pair(make_pair(-ONE, -MAXC, -MAXC, '0, MAXC, MAXC, '0, '0, '0, ONE, ONE, ONE));
      // swapped corners, both direction signs
      send_pair(make_pair(ONE, -ONE, -ONE, -ONE, ONE, ONE, '0, '0, '0, ONE, ONE, ONE));
      send_pair(make_pair(ONE, ONE, -ONE, -ONE, -ONE, ONE, '0, '0, '0, -ONE, -ONE, ONE));
      // field extremes and largest products
      send_pair(make_pair(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                          MAXC, MAXC, MAXC));
      send_pair(make_pair(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC,
                          MINC, MINC, MINC));
      send_pair(make_pair(MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MINC,
                          MAXC, MAXC, MAXC));
      send_pair(make_pair(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                          MINC, MINC, MINC));
      send_pair(make_pair(MINC, MINC, MINC, MAXC, MAXC, MAXC, '0, '0, '0, MINC, MAXC, 1));
      send_pair(make_pair(MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, '0,
                          -1, MINC, MAXC));
      // smallest nonzero directions, then unit directions with zero on z
      send_pair(make_pair(-ONE, -ONE, -ONE, ONE, ONE, ONE, -2*ONE, '0, '0, 1, -1, 1));
      send_pair(make_pair(-ONE, -ONE, -ONE, ONE, ONE, ONE, '0, '0, '0, ONE, -ONE, '0));

      // random pairs, with one stretch of back-to-back traffic
      for (n = 0; n < RANDOM_PAIRS; n++) begin
         calm_phase = (n >= 500 && n < 700);
         send_pair(random_pair());
      end
      calm_phase = 1'b0;
      req_tvalid <= 1'b0;

      // drain outstanding results, then allow for stray responses
      do @(posedge clock); while (hits_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && hits_pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #(10_000_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule
